>>> design/mavf_pkg.sv
// Package: shared constants, state encoding and control structs for the moving average filter
`default_nettype none

package mavf_pkg;

   // Default sizes, handed to the top level parameters
   localparam int MAX_WINDOW_DEF    = 64;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 8;

   // Window length register
   localparam int               WINDOW_BITS  = 7;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd8;
   localparam int               WINDOW_MIN   = 2;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PREP,
      ST_START,
      ST_WAIT,
      ST_HOLD
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;   // latch sample, advance position and count, read oldest
      logic load;     // write ring, capture oldest, form warm-up product
      logic prep;     // form dividend
      logic start;    // launch divider
      logic finish;   // update average, load result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic div_done;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

>>> design/moving_average_filter_unit.sv
// Top level: moving average filter with cumulative warm-up
//
// Channels: req_ (one signed sample per item), rsp_ (average with
// FRACTION_BITS fraction bits plus a status bit, 1 while warming up),
// csr_ (window length write, ready outside reset; write it only while no
// item is in flight). req_ready and csr_ready stay low while reset is held.
// Each item: accept cycle, ring read and product, dividend, divider launch,
// then a restoring divider that produces one quotient bit per cycle and
// then applies the sign, then the result register load. The dividend is
// SAMPLE_BITS+FRACTION_BITS+clog2(MAX_WINDOW+2)+1 bits wide. A new item is
// accepted only once the controller is back in idle after the result
// register load, so only one item is in work at a time.
// A finished result sits in the output register while the next item is
// accepted and worked on; if the receiver still stalls when the next result
// is ready, the controller holds that result until the register frees up.
// Reset (synchronous) sets window length 8 and clears count, position and
// average; a window length write clears the same three. Ring entries need
// no clearing: an entry is read as the oldest sample only after it was
// written in the current run.
`default_nettype none

module moving_average_filter_unit #(
   parameter int MAX_WINDOW    = mavf_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS   = mavf_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = mavf_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]          req_sample,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] rsp_average,
   output logic                                        rsp_status,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [mavf_pkg::WINDOW_BITS-1:0]       csr_wdata
);

   mavf_pkg::cmd_type    cmd;
   mavf_pkg::status_type status;

   // Sequencer
   mavf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, storage and result register
   mavf_datapath #(
      .MAX_WINDOW    (MAX_WINDOW),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_sample),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_average (rsp_average),
      .rsp_status  (rsp_status)
   );

endmodule

`default_nettype wire

>>> design/mavf_ram.sv
// Generic single write port, single read port RAM with registered read data
`default_nettype none

module mavf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/mavf_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module mavf_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 7
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0]        denom,
   output logic                         done,
   output logic signed [NUM_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [NUM_W-1:0]        quo_ff;
   logic                    neg_ff;
   logic signed [NUM_W-1:0] q_ff;

   logic [NUM_W-1:0] mag;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   // Magnitude of dividend and one trial subtraction
   always_comb begin
      mag     = numer[NUM_W-1] ? (~numer + NUM_W'(1)) : numer;
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = (shifted >= {1'b0, den_ff});
      diff    = shifted - {1'b0, den_ff};
   end

   // Control: busy flag, step counter, done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == STEP_W'(NUM_W)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + STEP_W'(1);
            end
         end
      end
   end

   // Datapath: shift in dividend bits, then apply sign
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= mag;
         rem_ff <= '0;
         den_ff <= denom;
         neg_ff <= numer[NUM_W-1];
      end else if (busy_ff) begin
         if (step_ff == STEP_W'(NUM_W)) begin
            q_ff <= neg_ff ? $signed(~quo_ff + NUM_W'(1)) : $signed(quo_ff);
         end else begin
            rem_ff <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

>>> design/mavf_datapath.sv
// Datapath: window register, ring buffer, count and position, divider, result register
`default_nettype none

module mavf_datapath #(
   parameter int MAX_WINDOW    = mavf_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS   = mavf_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = mavf_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire mavf_pkg::cmd_type                      cmd,
   output mavf_pkg::status_type                        status,
   input  wire logic signed [SAMPLE_BITS-1:0]          req_sample,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [mavf_pkg::WINDOW_BITS-1:0]       csr_wdata,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] rsp_average,
   output logic                                        rsp_status
);

   localparam int AVG_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int CNT_W    = $clog2(MAX_WINDOW + 2);
   localparam int POS_W    = $clog2(MAX_WINDOW);
   localparam int NUM_W    = AVG_BITS + CNT_W + 1;
   localparam logic signed [NUM_W:0] AVG_HI =
      {{(NUM_W - AVG_BITS + 2){1'b0}}, {(AVG_BITS - 1){1'b1}}};
   localparam logic signed [NUM_W:0] AVG_LO = ~AVG_HI;

   // Registers
   logic [mavf_pkg::WINDOW_BITS-1:0] window_ff;
   logic [CNT_W-1:0]                 count_ff;
   logic [POS_W-1:0]                 pos_ff;
   logic signed [AVG_BITS-1:0]       avg_ff;
   logic signed [SAMPLE_BITS-1:0]    x_ff;
   logic [POS_W-1:0]                 wr_pos_ff;
   logic                             full_ff;
   logic signed [SAMPLE_BITS-1:0]    oldest_ff;
   logic signed [NUM_W-1:0]          prod_ff;
   logic signed [NUM_W-1:0]          num_ff;
   logic                             rsp_valid_ff;
   logic signed [AVG_BITS-1:0]       rsp_average_ff;
   logic                             rsp_status_ff;

   // Next values and combinational terms
   logic [CNT_W-1:0]           win_len;
   logic [POS_W-1:0]           pos_cur;
   logic [CNT_W-1:0]           pos_inc;
   logic [POS_W-1:0]           pos_in;
   logic [CNT_W-1:0]           count_in;
   logic [CNT_W-1:0]           cnt_m1;
   logic signed [NUM_W-1:0]    prod_in;
   logic signed [NUM_W-1:0]    num_in;
   logic [CNT_W-1:0]           divisor;
   logic signed [AVG_BITS-1:0] base;
   logic signed [NUM_W:0]      sum;
   logic signed [AVG_BITS-1:0] avg_in;
   logic [SAMPLE_BITS-1:0]     ram_rdata;
   logic                       div_done;
   logic signed [NUM_W-1:0]    div_q;
   logic                       csr_write;

   // Take register writes outside reset
   assign csr_ready = ~reset;
   assign csr_write = csr_valid & csr_ready;

   // Clamp window length into its legal range
   always_comb begin
      if (32'(window_ff) < mavf_pkg::WINDOW_MIN) begin
         win_len = CNT_W'(mavf_pkg::WINDOW_MIN);
      end else if (32'(window_ff) > MAX_WINDOW) begin
         win_len = CNT_W'(MAX_WINDOW);
      end else begin
         win_len = CNT_W'(window_ff);
      end
   end

   // Position wrap and saturating count
   always_comb begin
      pos_cur  = (CNT_W'(pos_ff) >= win_len) ? '0 : pos_ff;
      pos_inc  = CNT_W'(pos_cur) + CNT_W'(1);
      pos_in   = (pos_inc >= win_len) ? '0 : pos_inc[POS_W-1:0];
      count_in = (count_ff <= win_len) ? (count_ff + CNT_W'(1)) : count_ff;
   end

   // Warm-up product, dividend and divisor
   always_comb begin
      cnt_m1  = count_ff - CNT_W'(1);
      prod_in = NUM_W'($signed({1'b0, cnt_m1})) * NUM_W'(avg_ff);
      if (full_ff) begin
         num_in  = (NUM_W'(x_ff) - NUM_W'(oldest_ff)) <<< FRACTION_BITS;
         divisor = win_len;
      end else begin
         num_in  = prod_ff + (NUM_W'(x_ff) <<< FRACTION_BITS);
         divisor = count_ff;
      end
   end

   // Final add and saturation
   always_comb begin
      if (full_ff) begin
         base = avg_ff;
      end else begin
         base = '0;
      end
      sum = (NUM_W + 1)'(base) + (NUM_W + 1)'(div_q);
      if (sum > AVG_HI) begin
         avg_in = AVG_HI[AVG_BITS-1:0];
      end else if (sum < AVG_LO) begin
         avg_in = AVG_LO[AVG_BITS-1:0];
      end else begin
         avg_in = sum[AVG_BITS-1:0];
      end
   end

   // Run state: window, count, position, average
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= mavf_pkg::WINDOW_RESET;
         count_ff  <= '0;
         pos_ff    <= '0;
         avg_ff    <= '0;
      end else if (csr_write) begin
         window_ff <= csr_wdata;
         count_ff  <= '0;
         pos_ff    <= '0;
         avg_ff    <= '0;
      end else begin
         if (cmd.accept) begin
            count_ff <= count_in;
            pos_ff   <= pos_in;
         end
         if (cmd.finish) begin
            avg_ff <= avg_in;
         end
      end
   end

   // Per-item working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff      <= req_sample;
         wr_pos_ff <= pos_cur;
         full_ff   <= (count_in > win_len);
      end
      if (cmd.load) begin
         oldest_ff <= $signed(ram_rdata);
         prod_ff   <= prod_in;
      end
      if (cmd.prep) begin
         num_ff <= num_in;
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_average_ff <= avg_in;
         rsp_status_ff  <= ~full_ff;
      end
   end

   // Sample ring
   mavf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (wr_pos_ff),
      .wr_data (x_ff),
      .rd_en   (cmd.accept),
      .rd_addr (pos_cur),
      .rd_data (ram_rdata)
   );

   // Single divider, used in both warm-up and full-window mode
   mavf_divider #(
      .NUM_W (NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .numer    (num_ff),
      .denom    (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign status.div_done = div_done;
   assign status.out_busy = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

>>> design/mavf_ctrl.sv
// Controller: sequences one item through load, dividend, divide and result
`default_nettype none

module mavf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mavf_pkg::status_type status,
   output mavf_pkg::cmd_type         cmd
);

   mavf_pkg::state_type state_ff;
   mavf_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mavf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         mavf_pkg::ST_IDLE: begin
            // Take no item while reset is held
            req_ready = ~reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = mavf_pkg::ST_LOAD;
            end
         end
         mavf_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = mavf_pkg::ST_PREP;
         end
         mavf_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = mavf_pkg::ST_START;
         end
         mavf_pkg::ST_START: begin
            cmd.start = 1'b1;
            state_in  = mavf_pkg::ST_WAIT;
         end
         mavf_pkg::ST_WAIT: begin
            if (status.div_done) begin
               if (!status.out_busy) begin
                  cmd.finish = 1'b1;
                  state_in   = mavf_pkg::ST_IDLE;
               end else begin
                  state_in = mavf_pkg::ST_HOLD;
               end
            end
         end
         mavf_pkg::ST_HOLD: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = mavf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mavf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/mavf_checker.sv
// Port-level checker for the moving average filter, bound to the top level
`default_nettype none

module mavf_checker #(
   parameter int SAMPLE_BITS   = mavf_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = mavf_pkg::FRACTION_BITS_DEF
) (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] rsp_average,
   input wire logic                                   rsp_status
);

   // Stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average) && $stable(rsp_status))
      else $error("stalled result changed or dropped");

   // Reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // One item at a time: no new item is taken while the previous one is in work
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("item accepted while previous item still in work");

   // A new result appears exactly as the block goes back to taking items
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while block still busy");

endmodule

bind moving_average_filter_unit mavf_checker #(
   .SAMPLE_BITS   (SAMPLE_BITS),
   .FRACTION_BITS (FRACTION_BITS)
) u_mavf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_average (rsp_average),
   .rsp_status  (rsp_status)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the moving average filter unit
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W = mavf_pkg::SAMPLE_BITS_DEF;
   localparam int FRAC     = mavf_pkg::FRACTION_BITS_DEF;
   localparam int AVG_W    = SAMPLE_W + FRAC;
   localparam int MAX_W    = mavf_pkg::MAX_WINDOW_DEF;
   localparam int WIN_W    = mavf_pkg::WINDOW_BITS;
   localparam longint SCALE   = longint'(1) << FRAC;
   localparam longint AVG_MAX = (longint'(1) << (AVG_W - 1)) - 1;
   localparam longint AVG_MIN = -AVG_MAX - 1;
   localparam int RANDOM_ITEMS = 650;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int WINDOW_EDGES [7] = '{0, 1, 2, 63, 64, 65, 127};

   typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      bit           typed;
      int           avg;
      bit           status;
   } stim_row_type;

   typedef struct packed {
      logic signed [AVG_W-1:0] average;
      logic                    status;
   } avg_result_type;

   // Directed rows: extremes, window clamping, warm-up, full window, saturation
   localparam int DIR_N = 29;
   stim_row_type directed_rows [DIR_N] = '{
      '{ROW_SAMPLE,      0, 1'b1,        0, 1'b1},
      '{ROW_SAMPLE,  32767, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b0,        0, 1'b0},
      '{ROW_WINDOW,      2, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b1, -8388608, 1'b1},
      '{ROW_SAMPLE,  32767, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      1, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,     -1, 1'b0,        0, 1'b0},
      '{ROW_WINDOW,      0, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,  32767, 1'b1,  8388352, 1'b1},
      '{ROW_SAMPLE,      5, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      7, 1'b0,        0, 1'b0},
      '{ROW_WINDOW,    127, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,    100, 1'b1,    25600, 1'b1},
      // window 3: build a one-LSB deficit by truncation, then slam to the floor
      '{ROW_WINDOW,      3, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      1, 1'b1,      256, 1'b1},
      '{ROW_SAMPLE,      1, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      1, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      2, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      1, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      1, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      4, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b1, -8388608, 1'b0},
      '{ROW_WINDOW,      1, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,     -5, 1'b1,    -1280, 1'b1},
      '{ROW_SAMPLE,      3, 1'b0,        0, 1'b0},
      '{ROW_SAMPLE,      0, 1'b0,        0, 1'b0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [AVG_W-1:0]    rsp_average;
   logic                       rsp_status;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [WIN_W-1:0]           csr_wdata = '0;

   // Filter state mirrored by the predictor
   logic signed [SAMPLE_W-1:0] ring_m [MAX_W];
   logic [WIN_W-1:0]           wlen_m = mavf_pkg::WINDOW_RESET;
   int unsigned                pos_m = 0;
   int unsigned                count_m = 0;
   longint                     avg_m = 0;

   avg_result_type pending_averages [$];
   int             fail_count = 0;
   int             rsp_count = 0;
   bit             sender_burst = 1'b0;

   moving_average_filter_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_average (rsp_average),
      .rsp_status  (rsp_status),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp the register value to the window the filter really uses
   function automatic int unsigned eff_window(input logic [WIN_W-1:0] w);
      int unsigned l;
      l = w;
      if (l < mavf_pkg::WINDOW_MIN) l = mavf_pkg::WINDOW_MIN;
      if (l > MAX_W) l = MAX_W;
      return l;
   endfunction

   function automatic longint sat_average(input longint v);
      if (v > AVG_MAX) return AVG_MAX;
      if (v < AVG_MIN) return AVG_MIN;
      return v;
   endfunction

   // Advance the mirrored filter by one sample and return the new average
   function automatic avg_result_type next_average(input logic signed [SAMPLE_W-1:0] x);
      int unsigned    l;
      int unsigned    p;
      longint         oldest;
      longint         xv;
      longint         n;
      avg_result_type r;
      l = eff_window(wlen_m);
      p = pos_m;
      if (p >= l) p = 0;
      oldest = ring_m[p];
      ring_m[p] = x;
      p++;
      if (p >= l) p = 0;
      pos_m = p;
      if (count_m <= l) count_m++;
      xv = x;
      n = count_m;
      if (count_m == 1) begin
         avg_m = xv * SCALE;
         r.status = 1'b1;
      end else if (count_m <= l) begin
         avg_m = sat_average(((n - 1) * avg_m + xv * SCALE) / n);
         r.status = 1'b1;
      end else begin
         avg_m = sat_average(avg_m + ((xv - oldest) * SCALE) / longint'(l));
         r.status = 1'b0;
      end
      r.average = avg_m[AVG_W-1:0];
      return r;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 40);
      return $urandom_range(60, 150);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 9))
         0: begin
            v = $urandom_range(0, 1) ? 32767 : -32768;
         end
         1, 2: begin
            v = int'($urandom_range(0, 200)) - 100;
         end
         3: begin
            if ($urandom_range(0, 1)) v = 32767 - int'($urandom_range(0, 15));
            else v = -32768 + int'($urandom_range(0, 15));
         end
         default: begin
            v = int'($urandom);
         end
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   // Offer one sample, hold it until taken, then queue its expected average
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input bit typed,
                              input int t_avg, input bit t_status);
      int unsigned    gap;
      avg_result_type r;
      gap = sender_burst ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= x;
      do @(posedge clock); while (!req_ready);
      r = next_average(x);
      if (typed) begin
         r.average = t_avg[AVG_W-1:0];
         r.status  = t_status;
      end
      pending_averages.push_back(r);
   endtask

   // Write the window length once every outstanding average has come back
   task automatic write_window(input logic [WIN_W-1:0] w);
      req_valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      wlen_m  = w;
      pos_m   = 0;
      count_m = 0;
      avg_m   = 0;
   endtask

   // Check each accepted item against the oldest expectation
   always @(posedge clock) begin
      avg_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_averages.size() == 0) begin
            $display("%0t: average %0d status %0d arrived with nothing outstanding",
                     $time, rsp_average, rsp_status);
            fail_count++;
         end else begin
            e = pending_averages.pop_front();
            if (rsp_average !== e.average) begin
               $display("%0t: average mismatch: expected %0d, actual %0d",
                        $time, e.average, rsp_average);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, e.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // Receiver: random stalls, long ready runs, and one long hold-off
   initial begin
      int unsigned gap;
      bit          hold_done;
      hold_done = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && rsp_count >= HOLD_AFTER && req_valid) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat (300) @(posedge clock);
            else repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Main sequence: reset, directed table, random phases, drain
   initial begin
      int               random_sent;
      int unsigned      l;
      int unsigned      len;
      logic [WIN_W-1:0] w;
      random_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_N; i++) begin
         if (directed_rows[i].kind == ROW_WINDOW) begin
            write_window(directed_rows[i].value[WIN_W-1:0]);
         end else begin
            send_sample(directed_rows[i].value[SAMPLE_W-1:0], directed_rows[i].typed,
                        directed_rows[i].avg, directed_rows[i].status);
         end
      end

      // Each phase: new window, then a run that mostly reaches the full window
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: w = WIN_W'($urandom_range(2, 8));
            3, 4:    w = WIN_W'(WINDOW_EDGES[$urandom_range(0, 6)]);
            default: w = WIN_W'($urandom_range(0, 127));
         endcase
         write_window(w);
         l = eff_window(w);
         if ($urandom_range(0, 4) == 0) len = $urandom_range(1, l);
         else len = l + $urandom_range(1, 40);
         sender_burst = ($urandom_range(0, 3) == 0);
         repeat (len) begin
            send_sample(pick_sample(), 1'b0, 0, 1'b0);
            random_sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("moving_average_filter_unit verification clean");
      end else begin
         $display("moving_average_filter_unit verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #15ms;
      $display("moving_average_filter_unit verification failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
design/mavf_pkg.sv
design/mavf_ram.sv
design/mavf_divider.sv
design/mavf_datapath.sv
design/mavf_ctrl.sv
design/moving_average_filter_unit.sv
design/mavf_checker.sv
tb/sv/tb_top.sv
